// ===== hw/rtl/nes_pkg.sv =====
// Shared constants and codes for the nearest edge selector.
// No dependencies; imported by the core and its square root unit.
`timescale 1ns / 1ps
`default_nettype none

package nes_pkg;

  localparam int MAX_POINTS     = 256;
  localparam int MAX_NEIGHBOURS = 16;
  localparam int PT_W           = $clog2(MAX_POINTS);
  localparam int SLOT_W         = $clog2(MAX_NEIGHBOURS);
  localparam int COORD_W        = 24;
  localparam int DIST_W         = 24;
  localparam int DEG_W          = 8;
  localparam int VTX_W          = 14;
  localparam int SQ_W           = 50;
  localparam int ROOT_W         = SQ_W / 2;
  localparam int CFG_W          = 24;

  typedef enum logic [1:0] {
    OP_POINT   = 2'd0,
    OP_SLOT    = 2'd1,
    OP_PROCESS = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_POINT_COUNT = 3'd0,
    CFG_MIN_DIST    = 3'd1,
    CFG_MAX_DIST    = 3'd2,
    CFG_CAND_EXAM   = 3'd3,
    CFG_EDGES_PER   = 3'd4,
    CFG_TIE_TOL     = 3'd5
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nes_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on nes_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module nes_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [nes_pkg::SQ_W-1:0]   radicand,
  output logic                            done,
  output logic [nes_pkg::ROOT_W-1:0]      root
);
  import nes_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] steps;
  logic             active;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem, rad[SQ_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= CNT_W'(ROOT_W);
        rad    <= radicand;
        rem    <= '0;
        root   <= '0;
      end else if (active) begin
        rad  <= {rad[SQ_W-3:0], 2'b00};
        rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root <= {root[ROOT_W-2:0], ge};
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_edge_selector_core.sv =====
// Nearest edge selector: point and neighbour stores, connection bitmap, degrees.
// Depends on nes_pkg and nes_isqrt.
//
// Load requests (point coordinates, neighbour slots) are written on the
// accept edge. A process request walks the point's neighbour list one
// candidate at a time: for each examined candidate, memory reads, three
// squares on one multiplier and the bit-serial square root, then one
// insertion-sort shift at a time. Each emitted edge then takes a
// read-modify-write on the degree and bitmap memories plus however
// long the result waits on out_stall. After reset the block clears the
// 256 rows of the bitmap and degree memories, one row a cycle, with in_stall
// held high; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module nearest_edge_selector_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              wr_en,
  input  wire logic [2:0]                        wr_index,
  input  wire logic [nes_pkg::CFG_W-1:0]         wr_data,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        opcode,
  input  wire logic [nes_pkg::PT_W-1:0]          point_index,
  input  wire logic [nes_pkg::SLOT_W-1:0]        slot,
  input  wire logic signed [8:0]                 neighbour_index,
  input  wire logic signed [nes_pkg::COORD_W-1:0] x,
  input  wire logic signed [nes_pkg::COORD_W-1:0] y,
  input  wire logic signed [nes_pkg::COORD_W-1:0] z,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   edge_valid,
  output logic [nes_pkg::PT_W-1:0]               from_index,
  output logic [nes_pkg::PT_W-1:0]               to_index,
  output logic signed [nes_pkg::COORD_W-1:0]     from_x,
  output logic signed [nes_pkg::COORD_W-1:0]     from_y,
  output logic signed [nes_pkg::COORD_W-1:0]     from_z,
  output logic signed [nes_pkg::COORD_W-1:0]     to_x,
  output logic signed [nes_pkg::COORD_W-1:0]     to_y,
  output logic signed [nes_pkg::COORD_W-1:0]     to_z,
  output logic                                   last,
  output logic [nes_pkg::VTX_W-1:0]              vertex_total
);
  import nes_pkg::*;

  localparam int ROWS   = MAX_POINTS * MAX_POINTS / 256;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int BMA_W  = $clog2(MAX_POINTS * MAX_POINTS);
  localparam int NBA_W  = PT_W + SLOT_W;
  localparam int PTD_W  = 3 * COORD_W;
  localparam int CNT_W  = SLOT_W + 1;

  typedef enum logic [17:0] {
    S_CLEAR  = 18'h00001,
    S_IDLE   = 18'h00002,
    S_PREAD  = 18'h00004,
    S_NREAD  = 18'h00008,
    S_NCHK   = 18'h00010,
    S_CREAD  = 18'h00020,
    S_BIT1   = 18'h00040,
    S_BIT2   = 18'h00080,
    S_SQ     = 18'h00100,
    S_RSTART = 18'h00200,
    S_RWAIT  = 18'h00400,
    S_FILTER = 18'h00800,
    S_INS    = 18'h01000,
    S_ESTART = 18'h02000,
    S_EREAD  = 18'h04000,
    S_EDEG   = 18'h08000,
    S_EWR    = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  // Bitmap address of the connection from one point to another.
  function automatic logic [BMA_W-1:0] bit_addr(input logic [PT_W-1:0] a,
                                                input logic [PT_W-1:0] b,
                                                input logic [8:0]      stride);
    logic [PT_W+9:0] full;
    full = (PT_W+10)'(a) * (PT_W+10)'(stride) + (PT_W+10)'(b);
    return full[BMA_W-1:0];
  endfunction

  // configuration registers
  logic [8:0]        point_count;
  logic [DIST_W-1:0] min_distance;
  logic [DIST_W-1:0] max_distance;
  logic [4:0]        candidates_examined;
  logic [4:0]        edges_per_point;
  logic [DIST_W-1:0] tie_tolerance;

  // memories
  logic [PTD_W-1:0]  pt_mem [MAX_POINTS];
  logic [8:0]        nb_mem [MAX_POINTS*MAX_NEIGHBOURS];
  logic [255:0]      bm_mem [ROWS];
  logic [DEG_W-1:0]  deg_mem [MAX_POINTS];

  logic [PTD_W-1:0]  pt_rdata;
  logic [8:0]        nb_rdata;
  logic [255:0]      bm_rdata;
  logic [DEG_W-1:0]  deg_rdata;

  logic              pt_we, nb_we, bm_we, deg_we;
  logic [PT_W-1:0]   pt_ra, deg_ra, deg_wa;
  logic [NBA_W-1:0]  nb_ra;
  logic [ROW_AW-1:0] bm_ra, bm_wa;
  logic [255:0]      bm_wd;
  logic [DEG_W-1:0]  deg_wd;

  // control and datapath registers
  state_t            state;
  logic [ROW_AW-1:0] clr;
  logic [PT_W-1:0]   pi;
  logic [PT_W-1:0]   cand;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  nv;
  logic [SLOT_W-1:0] k;
  logic [SLOT_W-1:0] e;
  logic [DEG_W-1:0]  cdeg;
  logic [COORD_W-1:0] p_x, p_y, p_z, c_x, c_y, c_z;
  logic              bit1, link;
  logic [1:0]        m;
  logic [SQ_W-1:0]   sq, acc;
  logic [DIST_W-1:0] cand_len;
  logic [VTX_W-1:0]  vtotal;

  logic [DIST_W-1:0] cb_dist [MAX_NEIGHBOURS];
  logic [PT_W-1:0]   cb_pt   [MAX_NEIGHBOURS];
  logic [DEG_W-1:0]  cb_deg  [MAX_NEIGHBOURS];

  logic              accept;
  logic [CNT_W-1:0]  exam_cap, emit_cnt;
  logic [BMA_W-1:0]  afwd, arev;
  logic [PT_W-1:0]   ecand;
  logic [SLOT_W-1:0] km1;
  logic signed [COORD_W:0] dsel;
  logic [COORD_W:0]  absd;
  logic [SQ_W-1:0]   sqd;
  logic [DIST_W-1:0] tdiff;
  logic              goes_first;
  logic              reject;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && !in_stall;

  nes_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (acc),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );
  assign sqrt_start = (state == S_RSTART);

  // Cap the list walk at the list length; the edge count is capped by nv.
  always_comb begin
    exam_cap = (candidates_examined > CNT_W'(MAX_NEIGHBOURS)) ?
               CNT_W'(MAX_NEIGHBOURS) : candidates_examined;
    emit_cnt = (edges_per_point < nv) ? edges_per_point : nv;
    afwd     = bit_addr(pi, cand, point_count);
    arev     = bit_addr(cand, pi, point_count);
    ecand    = cb_pt[e];
    km1      = k - SLOT_W'(1);
  end

  // One coordinate difference a cycle feeds the shared multiplier.
  always_comb begin
    case (m)
      2'd0:    dsel = {p_x[COORD_W-1], p_x} - {c_x[COORD_W-1], c_x};
      2'd1:    dsel = {p_y[COORD_W-1], p_y} - {c_y[COORD_W-1], c_y};
      2'd2:    dsel = {p_z[COORD_W-1], p_z} - {c_z[COORD_W-1], c_z};
      default: dsel = '0;
    endcase
    absd = dsel[COORD_W] ? (COORD_W+1)'(-dsel) : (COORD_W+1)'(dsel);
    sqd  = absd * absd;
  end

  // Near-equal distances order by lower degree, else by shorter distance.
  always_comb begin
    tdiff = (cand_len > cb_dist[km1]) ? cand_len - cb_dist[km1]
                                      : cb_dist[km1] - cand_len;
    goes_first = (tdiff < tie_tolerance) ? (cdeg < cb_deg[km1])
                                         : (cand_len < cb_dist[km1]);
    reject = (cand == pi) || (cand_len < min_distance) ||
             (cand_len > max_distance) || link;
  end

  // memory ports
  always_comb begin
    pt_we  = accept && (opcode == OP_POINT);
    nb_we  = accept && (opcode == OP_SLOT);
    pt_ra  = pi;
    nb_ra  = {pi, j[SLOT_W-1:0]};
    deg_ra = nb_rdata[PT_W-1:0];
    bm_ra  = afwd[BMA_W-1 -: ROW_AW];
    bm_we  = 1'b0;
    bm_wa  = afwd[BMA_W-1 -: ROW_AW];
    bm_wd  = bm_rdata | (256'(1) << afwd[7:0]);
    deg_we = 1'b0;
    deg_wa = cand;
    deg_wd = deg_rdata + DEG_W'(1);
    case (state)
      S_CLEAR: begin
        bm_we  = 1'b1;
        bm_wa  = clr;
        bm_wd  = '0;
        deg_we = 1'b1;
        deg_wa = clr;
        deg_wd = '0;
      end
      S_NCHK: begin
        pt_ra = nb_rdata[PT_W-1:0];
      end
      S_BIT1: begin
        bm_ra = arev[BMA_W-1 -: ROW_AW];
      end
      S_EREAD: begin
        pt_ra  = ecand;
        deg_ra = pi;
      end
      S_EDEG: begin
        deg_we = 1'b1;
        deg_wa = pi;
        deg_ra = cand;
      end
      S_EWR: begin
        deg_we = 1'b1;
        bm_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[point_index] <= {x, y, z};
    end
    pt_rdata <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[{point_index, slot}] <= neighbour_index;
    end
    nb_rdata <= nb_mem[nb_ra];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    bm_rdata <= bm_mem[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_rdata <= deg_mem[deg_ra];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count         <= '0;
      min_distance        <= '0;
      max_distance        <= '1;
      candidates_examined <= 5'd16;
      edges_per_point     <= 5'd4;
      tie_tolerance       <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_POINT_COUNT: point_count         <= wr_data[8:0];
        CFG_MIN_DIST:    min_distance        <= wr_data;
        CFG_MAX_DIST:    max_distance        <= wr_data;
        CFG_CAND_EXAM:   candidates_examined <= wr_data[4:0];
        CFG_EDGES_PER:   edges_per_point     <= wr_data[4:0];
        CFG_TIE_TOL:     tie_tolerance       <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      vtotal <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + ROW_AW'(1);
          if (clr == ROW_AW'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          // loads complete on the accept edge; only a process request moves on
          if (accept && (opcode == OP_PROCESS)) begin
            pi    <= point_index;
            j     <= '0;
            nv    <= '0;
            state <= S_PREAD;
          end
        end
        S_PREAD: begin
          state <= S_NREAD;
        end
        S_NREAD: begin
          if (j == '0) begin
            {p_x, p_y, p_z} <= pt_rdata;
          end
          state <= (j >= exam_cap) ? S_ESTART : S_NCHK;
        end
        S_NCHK: begin
          // a negative entry ends the list
          if (nb_rdata[8]) begin
            state <= S_ESTART;
          end else begin
            cand  <= nb_rdata[PT_W-1:0];
            state <= S_CREAD;
          end
        end
        S_CREAD: begin
          {c_x, c_y, c_z} <= pt_rdata;
          cdeg  <= deg_rdata;
          state <= S_BIT1;
        end
        S_BIT1: begin
          bit1  <= bm_rdata[afwd[7:0]];
          state <= S_BIT2;
        end
        S_BIT2: begin
          link  <= bit1 || bm_rdata[arev[7:0]];
          m     <= '0;
          acc   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (m != 2'd3) begin
            sq <= sqd;
          end
          if (m != 2'd0) begin
            acc <= acc + sq;
          end
          m <= m + 2'd1;
          if (m == 2'd3) begin
            state <= S_RSTART;
          end
        end
        S_RSTART: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (sqrt_done) begin
            cand_len <= sqrt_root[ROOT_W-1] ? '1 : sqrt_root[DIST_W-1:0];
            state    <= S_FILTER;
          end
        end
        S_FILTER: begin
          if (reject) begin
            j     <= j + CNT_W'(1);
            state <= S_NREAD;
          end else begin
            k     <= nv[SLOT_W-1:0];
            state <= S_INS;
          end
        end
        S_INS: begin
          // shift one entry down per cycle until the slot is found
          if ((k != '0) && goes_first) begin
            cb_dist[k] <= cb_dist[km1];
            cb_pt[k]   <= cb_pt[km1];
            cb_deg[k]  <= cb_deg[km1];
            k          <= km1;
          end else begin
            cb_dist[k] <= cand_len;
            cb_pt[k]   <= cand;
            cb_deg[k]  <= cdeg;
            nv         <= nv + CNT_W'(1);
            j          <= j + CNT_W'(1);
            state      <= S_NREAD;
          end
        end
        S_ESTART: begin
          e <= '0;
          if (emit_cnt == '0) begin
            edge_valid   <= 1'b0;
            from_index   <= '0;
            to_index     <= '0;
            from_x       <= '0;
            from_y       <= '0;
            from_z       <= '0;
            to_x         <= '0;
            to_y         <= '0;
            to_z         <= '0;
            last         <= 1'b1;
            vertex_total <= vtotal;
            state        <= S_OUT;
          end else begin
            state <= S_EREAD;
          end
        end
        S_EREAD: begin
          cand  <= ecand;
          state <= S_EDEG;
        end
        S_EDEG: begin
          {c_x, c_y, c_z} <= pt_rdata;
          state <= S_EWR;
        end
        S_EWR: begin
          edge_valid   <= 1'b1;
          from_index   <= pi;
          to_index     <= cand;
          from_x       <= p_x;
          from_y       <= p_y;
          from_z       <= p_z;
          to_x         <= c_x;
          to_y         <= c_y;
          to_z         <= c_z;
          last         <= (CNT_W'(e) + CNT_W'(1)) == emit_cnt;
          vertex_total <= vtotal + VTX_W'(2);
          vtotal       <= vtotal + VTX_W'(2);
          state        <= S_OUT;
        end
        S_OUT: begin
          // hold the result until the far side takes it
          if (!out_stall) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              e     <= e + SLOT_W'(1);
              state <= S_EREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nes_checker.sv =====
// Port-level checks for the nearest edge selector core, and its bind.
// Depends on nearest_edge_selector_core port names only.
`timescale 1ns / 1ps
`default_nettype none

module nes_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       edge_valid,
  input wire logic       last,
  input wire logic [7:0] from_index,
  input wire logic [7:0] to_index
);

  // a pending result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // no new request is taken while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");

  // an empty result is always the final one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_valid |-> last)
    else $error("empty result not marked last");

  // self edges are never emitted
  a_no_self: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_valid |-> from_index != to_index)
    else $error("self edge emitted");

  // the clearing pass holds off requests right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("request port open right after reset");

endmodule

bind nearest_edge_selector_core nes_checker u_nes_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .edge_valid (edge_valid),
  .last       (last),
  .from_index (from_index),
  .to_index   (to_index)
);

`default_nettype wire

// ===== verif/nearest_edge_selector_core_tb.sv =====
// Self-checking testbench for nearest_edge_selector_core: directed and random
// scenes of point loads, neighbour lists and process requests, checked per edge.
// Depends on nes_pkg and the core RTL only.
`timescale 1ns / 1ps

module nearest_edge_selector_core_tb;
  import nes_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;   // reserved opcode, block ignores it
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pi;
    logic [3:0]  slot;
    logic [8:0]  nb;
    logic [23:0] x, y, z;
  } request_t;

  typedef struct packed {
    logic        ev;
    logic [7:0]  fi, ti;
    logic [23:0] fx, fy, fz, tx, ty, tz;
    logic        lst;
    logic [13:0] vt;
  } edge_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [7:0] point_index = '0;
  logic [3:0] slot = '0;
  logic signed [8:0] neighbour_index = '0;
  logic signed [23:0] x = '0, y = '0, z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic edge_valid, last;
  logic [7:0] from_index, to_index;
  logic signed [23:0] from_x, from_y, from_z, to_x, to_y, to_z;
  logic [13:0] vertex_total;

  nearest_edge_selector_core uut (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .in_valid, .in_stall, .opcode, .point_index, .slot, .neighbour_index,
    .x, .y, .z,
    .out_valid, .out_stall, .edge_valid, .from_index, .to_index,
    .from_x, .from_y, .from_z, .to_x, .to_y, .to_z, .last, .vertex_total
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Request backlog and edge expectations
  request_t  pending_reqs[$];
  edge_rec_t expected_edges[$];
  int errors = 0;
  int reqs_taken = 0, edges_seen = 0, empties_seen = 0;

  // Shadow of the block: configuration
  logic [8:0]  sh_point_count;
  logic [23:0] sh_min_dist, sh_max_dist, sh_tie_tol;
  logic [4:0]  sh_cand_exam, sh_edges_per;

  // Shadow of the block: memories
  logic [23:0] sh_coord[256][3];
  logic [8:0]  sh_list[4096];
  bit          sh_linked[65536];
  logic [7:0]  sh_degree[256];
  logic [13:0] sh_vertices;

  // Generator bookkeeping (never lets the block read an unwritten entry)
  int list_len[256];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [23:0] edge_length(int a, int b);
    longint unsigned acc, r;
    longint d;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(sh_coord[a][k])) - longint'($signed(sh_coord[b][k]));
      if (d < 0) d = -d;
      acc += longint'(d) * longint'(d);
    end
    r = int_sqrt(acc);
    return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  function automatic int link_addr(int from, int to);
    return (from * int'(sh_point_count) + to) % 65536;
  endfunction

  // Near-equal lengths fall back to degree; otherwise shorter first
  function automatic bit ranks_ahead(logic [23:0] da, int pa, logic [23:0] db, int pb);
    logic [23:0] diff;
    diff = (da > db) ? da - db : db - da;
    if (diff < sh_tie_tol) return sh_degree[pa] < sh_degree[pb];
    return da < db;
  endfunction

  // Update the shadow for one accepted request and queue the edges it yields
  task automatic select_edges(request_t r);
    logic [23:0] ranked_len[16];
    int ranked_pt[16];
    int n, nv, cnt, c, k, p;
    logic [23:0] d;
    logic [8:0] raw;
    edge_rec_t e;
    p = int'(r.pi);
    case (r.op)
      OP_POINT: begin
        sh_coord[p][0] = r.x;
        sh_coord[p][1] = r.y;
        sh_coord[p][2] = r.z;
      end
      OP_SLOT: sh_list[p * 16 + int'(r.slot)] = r.nb;
      OP_PROCESS: begin
        n = (int'(sh_cand_exam) < 16) ? int'(sh_cand_exam) : 16;
        nv = 0;
        for (int j = 0; j < n; j++) begin
          raw = sh_list[p * 16 + j];
          if (raw[8]) break;
          c = int'(raw[7:0]);
          d = edge_length(p, c);
          if (c == p || d < sh_min_dist || d > sh_max_dist ||
              sh_linked[link_addr(p, c)] || sh_linked[link_addr(c, p)]) continue;
          k = nv;
          while (k > 0 && ranks_ahead(d, c, ranked_len[k-1], ranked_pt[k-1])) begin
            ranked_len[k] = ranked_len[k-1];
            ranked_pt[k] = ranked_pt[k-1];
            k--;
          end
          ranked_len[k] = d;
          ranked_pt[k] = c;
          nv++;
        end
        cnt = (int'(sh_edges_per) < nv) ? int'(sh_edges_per) : nv;
        if (cnt > 16) cnt = 16;
        if (cnt == 0) begin
          e = '0;
          e.lst = 1'b1;
          e.vt = sh_vertices;
          expected_edges = {expected_edges, e};
        end
        for (int j = 0; j < cnt; j++) begin
          c = ranked_pt[j];
          sh_linked[link_addr(p, c)] = 1'b1;
          sh_degree[p] = sh_degree[p] + 8'd1;
          sh_degree[c] = sh_degree[c] + 8'd1;
          sh_vertices = sh_vertices + 14'd2;
          e.ev = 1'b1;
          e.fi = 8'(p);
          e.ti = 8'(c);
          e.fx = sh_coord[p][0];
          e.fy = sh_coord[p][1];
          e.fz = sh_coord[p][2];
          e.tx = sh_coord[c][0];
          e.ty = sh_coord[c][1];
          e.tz = sh_coord[c][2];
          e.lst = (j + 1 == cnt);
          e.vt = sh_vertices;
          expected_edges = {expected_edges, e};
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: take a request at the rising edge, present the next one
  // (or a gap) at the falling edge.
  // ---------------------------------------------------------------------------
  request_t cur_req;
  bit req_taken = 1'b0;
  int in_gap = 0;
  bit in_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      select_edges(cur_req);
      reqs_taken++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      // occasionally flip between bursty and gappy traffic
      if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        opcode <= cur_req.op;
        point_index <= cur_req.pi;
        slot <= cur_req.slot;
        neighbour_index <= cur_req.nb;
        x <= cur_req.x;
        y <= cur_req.y;
        z <= cur_req.z;
        in_valid <= 1'b1;
        if (in_burst) in_gap = 0;
        else if ($urandom_range(0, 15) == 0) in_gap = int'($urandom_range(8, 50));
        else in_gap = int'($urandom_range(0, 2));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    edge_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, got from %0d to %0d",
                 $time, from_index, to_index);
        errors++;
      end else begin
        e = expected_edges.pop_front();
        check_field("edge_valid", 24'(e.ev), 24'(edge_valid));
        check_field("from_index", 24'(e.fi), 24'(from_index));
        check_field("to_index", 24'(e.ti), 24'(to_index));
        check_field("from_x", e.fx, from_x);
        check_field("from_y", e.fy, from_y);
        check_field("from_z", e.fz, from_z);
        check_field("to_x", e.tx, to_x);
        check_field("to_y", e.ty, to_y);
        check_field("to_z", e.tz, to_z);
        check_field("last", 24'(e.lst), 24'(last));
        check_field("vertex_total", 24'(e.vt), 24'(vertex_total));
        if (e.ev) edges_seen++;
        else empties_seen++;
      end
    end
  end

  // Random backpressure on the result side
  int out_hold = 0;
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
    end else if (in_burst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
      out_hold = ($urandom_range(0, 15) == 0) ? int'($urandom_range(8, 50))
                                              : int'($urandom_range(0, 2));
    end
  end

  // Watchdog: stop when nothing moves while work is outstanding
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_reqs.size() == 0 && !in_valid && expected_edges.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d requests and %0d results outstanding",
                 $time, pending_reqs.size(), expected_edges.size());
        $display("nearest_edge_selector_core_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [1:0] op, logic [7:0] pi, logic [3:0] sl,
                          logic [8:0] nb, logic [23:0] px, logic [23:0] py,
                          logic [23:0] pz);
    request_t r;
    r.op = op; r.pi = pi; r.slot = sl; r.nb = nb;
    r.x = px; r.y = py; r.z = pz;
    pending_reqs = {pending_reqs, r};
  endtask

  // Any junk in the unused fields, so every input bit toggles
  function automatic logic [23:0] junk24();
    return 24'($urandom());
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      CFG_POINT_COUNT: sh_point_count = val[8:0];
      CFG_MIN_DIST:    sh_min_dist = val[23:0];
      CFG_MAX_DIST:    sh_max_dist = val[23:0];
      CFG_CAND_EXAM:   sh_cand_exam = val[4:0];
      CFG_EDGES_PER:   sh_edges_per = val[4:0];
      CFG_TIE_TOL:     sh_tie_tol = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Hold until the request backlog and all expectations drain, then settle
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || in_valid || expected_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One scene: load a handful of points, give each a neighbour list, then
  // process them (twice, so the second pass sees existing connections).
  task automatic build_scene();
    int members[16];
    int npts, p, len, nsel;
    logic [23:0] base_x, base_y, base_z;
    bit spread;
    logic [8:0] nb;
    npts = int'($urandom_range(3, 5));
    spread = ($urandom_range(0, 3) == 0);
    base_x = 24'($urandom()); base_y = 24'($urandom()); base_z = 24'($urandom());
    for (int i = 0; i < npts; i++) begin
      members[i] = int'($urandom_range(0, 255));
      if (spread)
        push_req(OP_POINT, 8'(members[i]), 4'($urandom()), 9'($urandom()),
                 junk24(), junk24(), junk24());
      else
        push_req(OP_POINT, 8'(members[i]), 4'($urandom()), 9'($urandom()),
                 24'(base_x + 24'($urandom_range(0, 32767))),
                 24'(base_y + 24'($urandom_range(0, 32767))),
                 24'(base_z + 24'($urandom_range(0, 32767))));
    end
    for (int i = 0; i < npts; i++) begin
      p = members[i];
      len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 16))
                                        : int'($urandom_range(3, 12));
      for (int s = 0; s < len; s++)
        push_req(OP_SLOT, 8'(p), 4'(s), 9'(members[$urandom_range(0, npts - 1)]),
                 junk24(), junk24(), junk24());
      if (len < 16)
        push_req(OP_SLOT, 8'(p), 4'(len), {1'b1, 8'($urandom())},
                 junk24(), junk24(), junk24());
      list_len[p] = len;
    end
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < npts; i++) begin
        p = members[i];
        // sprinkle noise: reserved opcode or a rewrite inside the live list
        if ($urandom_range(0, 7) == 0)
          push_req(OP_UNUSED, 8'($urandom()), 4'($urandom()), 9'($urandom()),
                   junk24(), junk24(), junk24());
        if ($urandom_range(0, 5) == 0 && list_len[p] > 0) begin
          nsel = int'($urandom_range(0, list_len[p] - 1));
          nb = ($urandom_range(0, 5) == 0) ? {1'b1, 8'($urandom())}
                                           : 9'(members[$urandom_range(0, npts - 1)]);
          push_req(OP_SLOT, 8'(p), 4'(nsel), nb, junk24(), junk24(), junk24());
          if (nb[8]) list_len[p] = nsel;
        end
        push_req(OP_PROCESS, 8'(p), 4'($urandom()), 9'($urandom()),
                 junk24(), junk24(), junk24());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_start;
    // reset values of the register shadow
    sh_point_count = 9'd0;
    sh_min_dist = 24'd0;
    sh_max_dist = 24'hFFFFFF;
    sh_cand_exam = 5'd16;
    sh_edges_per = 5'd4;
    sh_tie_tol = 24'd0;
    sh_vertices = '0;
    for (int i = 0; i < 256; i++) begin
      sh_degree[i] = '0;
      for (int k = 0; k < 3; k++) sh_coord[i][k] = '0;
    end
    for (int i = 0; i < 4096; i++) sh_list[i] = '0;
    for (int i = 0; i < 65536; i++) sh_linked[i] = 1'b0;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: coordinate extremes, self, duplicate, saturated length,
    // a negative terminator other than -1, an empty list and the reserved op.
    push_req(OP_POINT, 8'd0, 4'd0, 9'd0, 24'h800000, 24'h800000, 24'h800000);
    push_req(OP_POINT, 8'd255, 4'd15, 9'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    push_req(OP_POINT, 8'd1, 4'd0, 9'd0, 24'h000000, 24'hFFFFFF, 24'h001000);
    push_req(OP_SLOT, 8'd0, 4'd0, 9'd255, '0, '0, '0);
    push_req(OP_SLOT, 8'd0, 4'd1, 9'd0, '0, '0, '0);
    push_req(OP_SLOT, 8'd0, 4'd2, 9'd1, '0, '0, '0);
    push_req(OP_SLOT, 8'd0, 4'd3, 9'd255, '0, '0, '0);
    push_req(OP_SLOT, 8'd0, 4'd4, 9'h1FE, '0, '0, '0);
    push_req(OP_SLOT, 8'd255, 4'd0, 9'd0, '0, '0, '0);
    push_req(OP_SLOT, 8'd255, 4'd1, 9'd1, '0, '0, '0);
    push_req(OP_SLOT, 8'd255, 4'd2, 9'h1FF, '0, '0, '0);
    push_req(OP_SLOT, 8'd1, 4'd0, 9'h100, '0, '0, '0);
    push_req(OP_UNUSED, 8'hFF, 4'hF, 9'h1FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    push_req(OP_PROCESS, 8'd0, 4'd0, 9'd0, '0, '0, '0);
    push_req(OP_PROCESS, 8'd255, 4'd0, 9'd0, '0, '0, '0);
    push_req(OP_PROCESS, 8'd1, 4'd0, 9'd0, '0, '0, '0);
    push_req(OP_PROCESS, 8'd0, 4'd0, 9'd0, '0, '0, '0);
    drain();

    // Random phases, each with its own register setting; extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_POINT_COUNT, 24'd256);
          write_reg(CFG_MIN_DIST, 24'd0);
          write_reg(CFG_MAX_DIST, 24'hFFFFFF);
          write_reg(CFG_CAND_EXAM, 24'd16);
          write_reg(CFG_EDGES_PER, 24'd16);
          write_reg(CFG_TIE_TOL, 24'd0);
        end
        1: begin
          write_reg(CFG_POINT_COUNT, 24'd0);
          write_reg(CFG_CAND_EXAM, 24'd31);
          write_reg(CFG_EDGES_PER, 24'd31);
          write_reg(CFG_TIE_TOL, 24'hFFFFFF);
        end
        2: begin
          write_reg(CFG_POINT_COUNT, 24'd1);
          write_reg(CFG_CAND_EXAM, 24'd0);
          write_reg(CFG_EDGES_PER, 24'd2);
          write_reg(CFG_TIE_TOL, 24'd0);
        end
        3: begin
          write_reg(CFG_POINT_COUNT, 24'd256);
          write_reg(CFG_MIN_DIST, 24'hFFFFFF);
          write_reg(CFG_CAND_EXAM, 24'd16);
          write_reg(CFG_EDGES_PER, 24'd0);
        end
        default: begin
          write_reg(CFG_POINT_COUNT, 24'($urandom_range(2, 511)));
          write_reg(CFG_MIN_DIST, 24'($urandom_range(0, 8192)));
          write_reg(CFG_MAX_DIST, 24'($urandom_range(16384, 1 << 20)));
          write_reg(CFG_CAND_EXAM, 24'($urandom_range(1, 16)));
          write_reg(CFG_EDGES_PER, 24'($urandom_range(1, 6)));
          write_reg(CFG_TIE_TOL, 24'($urandom_range(0, 8192)));
        end
      endcase
      phase_start = reqs_taken;
      while (reqs_taken + pending_reqs.size() - phase_start < 25) build_scene();
      drain();
    end

    $display("Covered %0d requests over 6 register settings plus a directed set;",
             reqs_taken);
    $display("checked %0d edges and %0d empty results.", edges_seen, empties_seen);
    if (errors == 0) begin
      $display("nearest_edge_selector_core_tb: done, clean");
    end else begin
      $display("nearest_edge_selector_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nes_pkg.sv
hw/rtl/nes_isqrt.sv
hw/rtl/nearest_edge_selector_core.sv
hw/rtl/nes_checker.sv
verif/nearest_edge_selector_core_tb.sv
